/* rtl/core/fsirc_pkg.sv */
// Shared types and codes for the first-seen id renumbering and count block.
// Used by fsirc_regs and first_seen_id_renumber_count; depends on nothing else.
package fsirc_pkg;

  // Transaction modes on the command port.
  localparam logic [1:0] MODE_OBSERVE = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Register word indexes on the configuration port.
  localparam logic REG_NUM_VALUES = 1'b0;
  localparam logic REG_RENUMBER   = 1'b1;

  // Width of the id fields on the ports.
  localparam int IdPortW = 13;

  // Configuration seen by the core.
  typedef struct packed {
    logic [IdPortW-1:0] num_values;
    logic               renumber_enable;
  } cfg_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAP   = 5'b00100,
    ST_BUMP  = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

endpackage

/* rtl/core/fsirc_regs.sv */
// Configuration registers behind the APB-style port.
// Depends on fsirc_pkg for the register indexes and the cfg_t struct.
module fsirc_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fsirc_pkg::cfg_t    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes; the word is picked by address bit 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_values      <= 13'd4096;
      cfg.renumber_enable <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == fsirc_pkg::REG_NUM_VALUES) begin
        cfg.num_values <= pwdata[fsirc_pkg::IdPortW-1:0];
      end else begin
        cfg.renumber_enable <= pwdata[0];
      end
    end
  end

  // Read back the addressed register.
  always_comb begin
    if (paddr[2] == fsirc_pkg::REG_RENUMBER) begin
      prdata = {31'd0, cfg.renumber_enable};
    end else begin
      prdata = {19'd0, cfg.num_values};
    end
  end

endmodule

/* rtl/core/first_seen_id_renumber_count.sv */
// From the accepting edge to the done strobe: an item in error is answered from ST_IDLE,
// a read passes through ST_READ, a plain-mode observe through ST_BUMP, a first sighting
// through ST_MAP, a seen id in renumber mode through ST_MAP (map read) and ST_BUMP (count
// read-modify-write), and a clear through ST_CLEAR over every address. One transaction is
// in flight at a time; the next one is taken at the edge that ends the done cycle.
// Reset starts a clearing pass over both memories, busy throughout.
// Results are shown for one cycle on done; the receiver cannot stall.
module first_seen_id_renumber_count #(
  parameter int MAX_VALUES  = 4096,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [12:0] old_id,
  input  logic [12:0] entry_index,
  output logic        done,
  output logic [12:0] new_id,
  output logic [12:0] unique_value,
  output logic [31:0] group_count,
  output logic [12:0] distinct_total,
  output logic        error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ID_W   = $clog2(MAX_VALUES + 1);
  localparam int ADDR_W = $clog2(MAX_VALUES);
  localparam int CW     = (ID_W > fsirc_pkg::IdPortW) ? ID_W : fsirc_pkg::IdPortW;
  localparam int ENT_W  = ID_W + COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VALUES - 1);

  fsirc_pkg::cfg_t   cfg;
  fsirc_pkg::state_t state;

  // Memories: old id to dense id, and per-slot {unique old id, count}.
  logic [ID_W-1:0]  id_map  [MAX_VALUES];
  logic [ENT_W-1:0] cnt_mem [MAX_VALUES];

  logic [ID_W-1:0]   map_q;
  logic [ENT_W-1:0]  cnt_q;
  logic              map_we, cnt_we;
  logic [ADDR_W-1:0] map_waddr, cnt_waddr, cnt_raddr;
  logic [ID_W-1:0]   map_wdata;
  logic [ENT_W-1:0]  cnt_wdata;

  // Sequencer registers.
  logic [ID_W-1:0]   next_new_id;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;
  logic [CW-1:0]     lat_old;
  logic [ADDR_W-1:0] lat_slot;
  logic [ADDR_W-1:0] lat_cslot;
  logic [ID_W-1:0]   lat_newid;
  logic [12:0]       lat_entry;

  // Range checks and address arithmetic.
  logic              accept;
  logic [CW-1:0]     old_x, entry_x, num_x, max_x, limit_x, next_x;
  logic [CW-1:0]     old_m1, entry_m1, next_m1, lat_newid_x, uniq_x;
  logic [ID_W-1:0]   map_m1;
  logic              obs_ok, rd_ok;
  logic [ADDR_W-1:0] old_addr, entry_addr;
  logic [COUNT_WIDTH-1:0] cnt_val, cnt_inc;
  logic [63:0]       cnt_ext;

  fsirc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = (state != fsirc_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign old_x   = CW'(old_id);
  assign entry_x = CW'(entry_index);
  assign num_x   = CW'(cfg.num_values);
  assign max_x   = CW'(MAX_VALUES);
  assign next_x  = CW'(next_new_id);
  assign limit_x = (num_x < max_x) ? num_x : max_x;

  assign obs_ok = (old_x != '0) && (old_x <= limit_x);
  assign rd_ok  = cfg.renumber_enable ? ((entry_x != '0) && (entry_x < next_x))
                                      : ((entry_x != '0) && (entry_x <= limit_x));

  assign old_m1     = old_x - CW'(1);
  assign entry_m1   = entry_x - CW'(1);
  assign next_m1    = next_x - CW'(1);
  assign old_addr   = old_m1[ADDR_W-1:0];
  assign entry_addr = entry_m1[ADDR_W-1:0];
  assign map_m1     = map_q - ID_W'(1);

  assign lat_newid_x = CW'(lat_newid);
  assign uniq_x      = CW'(cnt_q[ENT_W-1:COUNT_WIDTH]);
  assign cnt_val     = cnt_q[COUNT_WIDTH-1:0];
  assign cnt_inc     = (cnt_val == CNT_MAX) ? cnt_val : cnt_val + COUNT_WIDTH'(1);
  assign cnt_ext     = 64'(cnt_val);

  assign distinct_total = next_m1[12:0];

  // Count read address: seen-id slot in ST_MAP, else entry or old-id slot by mode.
  always_comb begin
    if (state == fsirc_pkg::ST_MAP) begin
      cnt_raddr = map_m1[ADDR_W-1:0];
    end else if (mode == fsirc_pkg::MODE_READ) begin
      cnt_raddr = entry_addr;
    end else begin
      cnt_raddr = old_addr;
    end
  end

  // Memory write controls for first sighting, count update and clearing.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = lat_slot;
    map_wdata = next_new_id;
    cnt_we    = 1'b0;
    cnt_waddr = lat_cslot;
    cnt_wdata = {cnt_q[ENT_W-1:COUNT_WIDTH], cnt_inc};
    case (state)
      fsirc_pkg::ST_MAP: begin
        if (map_q == '0) begin
          map_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_waddr = next_m1[ADDR_W-1:0];
          cnt_wdata = {lat_old[ID_W-1:0], COUNT_WIDTH'(1)};
        end
      end
      fsirc_pkg::ST_BUMP: begin
        cnt_we = 1'b1;
      end
      fsirc_pkg::ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // Id map memory, registered read.
  always_ff @(posedge clk) begin
    if (map_we) begin
      id_map[map_waddr] <= map_wdata;
    end
    map_q <= id_map[old_addr];
  end

  // Count memory, registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fsirc_pkg::ST_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      next_new_id <= ID_W'(1);
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        fsirc_pkg::ST_IDLE: begin
          if (accept) begin
            new_id       <= '0;
            unique_value <= '0;
            group_count  <= '0;
            error        <= 1'b0;
            lat_old      <= old_x;
            lat_slot     <= old_addr;
            lat_cslot    <= old_addr;
            lat_newid    <= '0;
            lat_entry    <= entry_index;
            case (mode)
              fsirc_pkg::MODE_OBSERVE: begin
                if (!obs_ok) begin
                  error <= 1'b1;
                  done  <= 1'b1;
                end else if (cfg.renumber_enable) begin
                  state <= fsirc_pkg::ST_MAP;
                end else begin
                  state <= fsirc_pkg::ST_BUMP;
                end
              end
              fsirc_pkg::MODE_READ: begin
                if (rd_ok) begin
                  state <= fsirc_pkg::ST_READ;
                end else begin
                  error <= 1'b1;
                  done  <= 1'b1;
                end
              end
              fsirc_pkg::MODE_CLEAR: begin
                state     <= fsirc_pkg::ST_CLEAR;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
              end
              default: begin
                error <= 1'b1;
                done  <= 1'b1;
              end
            endcase
          end
        end
        fsirc_pkg::ST_MAP: begin
          if (map_q == '0) begin
            // First sighting: hand out the next dense id.
            next_new_id <= next_new_id + ID_W'(1);
            new_id      <= next_x[12:0];
            done        <= 1'b1;
            state       <= fsirc_pkg::ST_IDLE;
          end else begin
            lat_newid <= map_q;
            lat_cslot <= map_m1[ADDR_W-1:0];
            state     <= fsirc_pkg::ST_BUMP;
          end
        end
        fsirc_pkg::ST_BUMP: begin
          new_id <= lat_newid_x[12:0];
          done   <= 1'b1;
          state  <= fsirc_pkg::ST_IDLE;
        end
        fsirc_pkg::ST_READ: begin
          unique_value <= cfg.renumber_enable ? uniq_x[12:0] : lat_entry;
          group_count  <= cnt_ext[31:0];
          done         <= 1'b1;
          state        <= fsirc_pkg::ST_IDLE;
        end
        fsirc_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            next_new_id <= ID_W'(1);
            done        <= clr_reply;
            clr_reply   <= 1'b0;
            state       <= fsirc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= fsirc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // A result only follows an accepted transaction or a working state.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past((state != fsirc_pkg::ST_IDLE) || (start && !busy)))
    else $error("done without a transaction in progress");

  // The memories are not written while the block is idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == fsirc_pkg::ST_IDLE) |-> (!map_we && !cnt_we))
    else $error("memory write while idle");

  // A first sighting advances the dense id counter by one.
  assert property (@(posedge clk) disable iff (rst)
    (state == fsirc_pkg::ST_MAP && map_q == '0)
      |=> (next_new_id == $past(next_new_id) + ID_W'(1)))
    else $error("dense id counter did not advance");

  // The reply to a clear reports an empty store.
  assert property (@(posedge clk) disable iff (rst)
    (done && $past(state == fsirc_pkg::ST_CLEAR)) |-> (distinct_total == '0))
    else $error("clear reply with nonzero distinct total");

  // While mapping, the dense id counter never passes one beyond the table depth.
  assert property (@(posedge clk) disable iff (rst)
    (state == fsirc_pkg::ST_MAP) |-> (next_x <= max_x + CW'(1)))
    else $error("dense id counter out of range");

endmodule
